/* rtl/core/iheap_pkg.sv */
// Shared constants and codes for the indexed min-heap queue.
package iheap_pkg;

    localparam int CAPACITY_DEF  = 1024;
    localparam int ID_SPACE_DEF  = 1024;
    localparam int KEY_WIDTH_DEF = 32;

    localparam int ID_W     = 10;
    localparam int LOC_W    = 10;
    localparam int PRIO_W   = 32;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 3;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_POP    = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_DUP    = 3'd2,
        ST_FULL   = 3'd3,
        ST_BADLOC = 3'd4
    } t_status;

endpackage

/* rtl/core/indexed_min_heap_queue.sv */
// Indexed binary min-heap priority queue with id-to-position map.
//
//  channel | direction | beat signals             | payload
//  --------+-----------+--------------------------+---------------------------------------
//  in      | to block  | i_in_valid / o_in_stall  | mode, priority_req, item_id, location
//  out     | from block| o_out_valid / i_out_stall| status, popped_id, popped_priority,
//          |           |                          | entry_count
//
// One beat in at a time; the block stalls its input until the result beat is taken.
// Insert: a map check, then an upward sift through S_UP_RD and S_UP_CMP for each level.
// Pop: setup in S_POP_RD1 and S_POP_RD2, an upward sift, then a downward sift through S_DN_L,
// S_DN_LW, S_DN_R and S_DN_C per level; the single heap read port and the one shared comparator force this order.
// Clear and reset sweep the map memory, one entry a cycle, over all ID_SPACE entries.
// Reset is synchronous, active low; no input beat is accepted during the sweep.
module indexed_min_heap_queue #(
    parameter int CAPACITY  = iheap_pkg::CAPACITY_DEF,
    parameter int ID_SPACE  = iheap_pkg::ID_SPACE_DEF,
    parameter int KEY_WIDTH = iheap_pkg::KEY_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [1:0]                             i_mode,
    input  logic signed [iheap_pkg::PRIO_W-1:0]    i_priority_req,
    input  logic [iheap_pkg::ID_W-1:0]             i_item_id,
    input  logic [iheap_pkg::LOC_W-1:0]            i_location,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [iheap_pkg::STATUS_W-1:0]         o_status,
    output logic [iheap_pkg::ID_W-1:0]             o_popped_id,
    output logic signed [iheap_pkg::PRIO_W-1:0]    o_popped_priority,
    output logic [iheap_pkg::COUNT_W-1:0]          o_entry_count
);

    localparam int PW  = $clog2(CAPACITY);
    localparam int IDW = $clog2(ID_SPACE);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int IW  = iheap_pkg::ID_W;
    localparam int HW  = KEY_WIDTH + IW;
    localparam int MW  = PW + 1;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_INS_CHK, S_POP_RD1, S_POP_RD2, S_UP_RD, S_UP_CMP,
        S_DN_L, S_DN_LW, S_DN_R, S_DN_C, S_DONE
    } t_state;

    // storage
    logic [HW-1:0] heap_mem [CAPACITY];
    logic [MW-1:0] map_mem  [ID_SPACE];

    t_state                      r_state, n_state;
    iheap_pkg::t_mode            r_mode, n_mode;
    iheap_pkg::t_status          r_status, n_status;
    logic                        r_boot, n_boot;
    logic [IDW-1:0]              r_clr_idx, n_clr_idx;
    logic [CW-1:0]               r_count, n_count;
    logic [PW-1:0]               r_i, n_i;
    logic [PW-1:0]               r_loc, n_loc;
    logic signed [KEY_WIDTH-1:0] r_cur_key, n_cur_key;
    logic [IW-1:0]               r_cur_id, n_cur_id;
    logic signed [KEY_WIDTH-1:0] r_ch_key, n_ch_key;
    logic [IW-1:0]               r_ch_id, n_ch_id;
    logic [PW-1:0]               r_ch_pos, n_ch_pos;
    logic [IW-1:0]               r_pid, n_pid;
    logic signed [31:0]          r_ppri, n_ppri;
    logic [HW-1:0]               r_hrd;
    logic [MW-1:0]               r_prd;

    logic [PW-1:0]  h_ra, h_wa;
    logic           h_we;
    logic [HW-1:0]  h_wd;
    logic [IDW-1:0] p_ra, p_wa;
    logic           p_we;
    logic [MW-1:0]  p_wd;

    logic signed [KEY_WIDTH-1:0] cmp_a, cmp_b;
    logic                        cmp_lt;

    logic signed [KEY_WIDTH-1:0] hrd_key;
    logic [IW-1:0]               hrd_id;
    logic [31:0] id_w, loc_w, cnt_w, lft_w, rgt_w, hid_w, cid_w, chid_w;
    logic [PW-1:0] parent;

    assign hrd_key = r_hrd[HW-1:IW];
    assign hrd_id  = r_hrd[IW-1:0];
    assign id_w    = 32'(i_item_id);
    assign loc_w   = 32'(i_location);
    assign cnt_w   = 32'(r_count);
    assign lft_w   = (32'(r_i) << 1) + 32'd1;
    assign rgt_w   = lft_w + 32'd1;
    assign hid_w   = 32'(hrd_id);
    assign cid_w   = 32'(r_cur_id);
    assign chid_w  = 32'(r_ch_id);
    assign parent  = PW'((r_i - PW'(1)) >> 1);

    // the one comparator, operands steered by state
    assign cmp_lt = cmp_a < cmp_b;

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_status  = r_status;
        n_boot    = r_boot;
        n_clr_idx = r_clr_idx;
        n_count   = r_count;
        n_i       = r_i;
        n_loc     = r_loc;
        n_cur_key = r_cur_key;
        n_cur_id  = r_cur_id;
        n_ch_key  = r_ch_key;
        n_ch_id   = r_ch_id;
        n_ch_pos  = r_ch_pos;
        n_pid     = r_pid;
        n_ppri    = r_ppri;
        h_ra      = '0;
        h_we      = 1'b0;
        h_wa      = r_i;
        h_wd      = {r_cur_key, r_cur_id};
        p_ra      = id_w[IDW-1:0];
        p_we      = 1'b0;
        p_wa      = cid_w[IDW-1:0];
        p_wd      = {1'b1, r_i};
        cmp_a     = r_cur_key;
        cmp_b     = hrd_key;

        case (r_state)
            S_CLR: begin
                p_we      = 1'b1;
                p_wa      = r_clr_idx;
                p_wd      = '0;
                n_clr_idx = r_clr_idx + IDW'(1);
                if (r_clr_idx == IDW'(ID_SPACE - 1)) begin
                    n_state = r_boot ? S_IDLE : S_DONE;
                    n_boot  = 1'b0;
                end
            end
            S_IDLE: begin
                p_ra = id_w[IDW-1:0];
                h_ra = loc_w[PW-1:0];
                if (i_in_valid) begin
                    n_mode    = iheap_pkg::t_mode'(i_mode);
                    n_status  = iheap_pkg::ST_OK;
                    n_pid     = '0;
                    n_ppri    = '0;
                    n_cur_key = KEY_WIDTH'(i_priority_req);
                    n_cur_id  = i_item_id;
                    n_loc     = loc_w[PW-1:0];
                    case (iheap_pkg::t_mode'(i_mode))
                        iheap_pkg::MODE_INSERT: begin
                            if (id_w >= 32'(ID_SPACE)) begin
                                n_status = iheap_pkg::ST_DUP;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_INS_CHK;
                            end
                        end
                        iheap_pkg::MODE_POP: begin
                            if (r_count == '0) begin
                                n_status = iheap_pkg::ST_EMPTY;
                                n_state  = S_DONE;
                            end else if (loc_w >= cnt_w) begin
                                n_status = iheap_pkg::ST_BADLOC;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_POP_RD1;
                            end
                        end
                        iheap_pkg::MODE_CLEAR: begin
                            n_count   = '0;
                            n_clr_idx = '0;
                            n_state   = S_CLR;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_INS_CHK: begin
                if (r_prd[PW]) begin
                    n_status = iheap_pkg::ST_DUP;
                    n_state  = S_DONE;
                end else if (r_count >= CW'(CAPACITY)) begin
                    n_status = iheap_pkg::ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_i     = PW'(r_count);
                    n_count = r_count + CW'(1);
                    n_state = S_UP_RD;
                end
            end
            S_POP_RD1: begin
                n_pid   = hrd_id;
                n_ppri  = 32'(hrd_key);
                p_we    = 1'b1;
                p_wa    = hid_w[IDW-1:0];
                p_wd    = '0;
                n_count = r_count - CW'(1);
                h_ra    = PW'(r_count - CW'(1));
                if (32'(r_loc) == cnt_w - 32'd1) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_POP_RD2;
                end
            end
            S_POP_RD2: begin
                n_cur_key = hrd_key;
                n_cur_id  = hrd_id;
                n_i       = r_loc;
                n_state   = S_UP_RD;
            end
            S_UP_RD: begin
                h_ra = parent;
                if (r_i == '0) begin
                    if (r_mode == iheap_pkg::MODE_POP) begin
                        n_state = S_DN_L;
                    end else begin
                        h_we    = 1'b1;
                        p_we    = 1'b1;
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (cmp_lt) begin
                    // parent drops into the hole
                    h_we    = 1'b1;
                    h_wd    = r_hrd;
                    p_we    = 1'b1;
                    p_wa    = hid_w[IDW-1:0];
                    n_i     = parent;
                    n_state = S_UP_RD;
                end else if (r_mode == iheap_pkg::MODE_POP) begin
                    n_state = S_DN_L;
                end else begin
                    h_we    = 1'b1;
                    p_we    = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DN_L: begin
                h_ra = lft_w[PW-1:0];
                if (lft_w >= cnt_w) begin
                    h_we    = 1'b1;
                    p_we    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DN_LW;
                end
            end
            S_DN_LW: begin
                n_ch_key = hrd_key;
                n_ch_id  = hrd_id;
                n_ch_pos = lft_w[PW-1:0];
                h_ra     = rgt_w[PW-1:0];
                n_state  = (rgt_w >= cnt_w) ? S_DN_C : S_DN_R;
            end
            S_DN_R: begin
                // right wins ties
                cmp_a = r_ch_key;
                cmp_b = hrd_key;
                if (!cmp_lt) begin
                    n_ch_key = hrd_key;
                    n_ch_id  = hrd_id;
                    n_ch_pos = rgt_w[PW-1:0];
                end
                n_state = S_DN_C;
            end
            S_DN_C: begin
                cmp_a = r_ch_key;
                cmp_b = r_cur_key;
                h_we  = 1'b1;
                p_we  = 1'b1;
                if (cmp_lt) begin
                    h_wd    = {r_ch_key, r_ch_id};
                    p_wa    = chid_w[IDW-1:0];
                    n_i     = r_ch_pos;
                    n_state = S_DN_L;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_boot    <= 1'b1;
            r_clr_idx <= '0;
            r_count   <= '0;
            r_mode    <= iheap_pkg::MODE_NOP;
            r_status  <= iheap_pkg::ST_OK;
        end else begin
            r_state   <= n_state;
            r_boot    <= n_boot;
            r_clr_idx <= n_clr_idx;
            r_count   <= n_count;
            r_mode    <= n_mode;
            r_status  <= n_status;
        end
        r_i       <= n_i;
        r_loc     <= n_loc;
        r_cur_key <= n_cur_key;
        r_cur_id  <= n_cur_id;
        r_ch_key  <= n_ch_key;
        r_ch_id   <= n_ch_id;
        r_ch_pos  <= n_ch_pos;
        r_pid     <= n_pid;
        r_ppri    <= n_ppri;
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            heap_mem[h_wa] <= h_wd;
        end
        r_hrd <= heap_mem[h_ra];
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            map_mem[p_wa] <= p_wd;
        end
        r_prd <= map_mem[p_ra];
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = (r_state == S_DONE);
    assign o_status          = r_status;
    assign o_popped_id       = r_pid;
    assign o_popped_priority = r_ppri;
    assign o_entry_count     = iheap_pkg::COUNT_W'(r_count);

endmodule

/* rtl/core/iheap_checker.sv */
// Port-level checks for the indexed min-heap queue, bound to the queue module.
module iheap_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [iheap_pkg::STATUS_W-1:0]      o_status,
    input logic [iheap_pkg::ID_W-1:0]          o_popped_id,
    input logic signed [iheap_pkg::PRIO_W-1:0] o_popped_priority,
    input logic [iheap_pkg::COUNT_W-1:0]       o_entry_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_entry_count))
        else $error("result beat changed while stalled");

    a_busy_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result is pending");

    a_no_pop_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != iheap_pkg::ST_OK |->
            o_popped_id == '0 && o_popped_priority == '0)
        else $error("popped fields set on a failed step");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == iheap_pkg::ST_EMPTY |-> o_entry_count == '0)
        else $error("empty status with nonzero count");

endmodule

bind indexed_min_heap_queue iheap_checker u_iheap_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_status          (o_status),
    .o_popped_id       (o_popped_id),
    .o_popped_priority (o_popped_priority),
    .o_entry_count     (o_entry_count)
);
